/* rtl/core/srt_pkg.sv */
package srt_pkg;

	// command queue between the classifier and the event expander
	localparam int CMD_QUEUE_DEPTH = 2;

	// most events that one item can cause
	localparam int MAX_EVENTS = 4;

	// byte codes with a meaning of their own
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;

	typedef enum logic [2:0] {
		EV_ARG_BYTE  = 3'd0,
		EV_ARG_END   = 3'd1,
		EV_TGT_BYTE  = 3'd2,
		EV_TGT_END   = 3'd3,
		EV_LINE_DONE = 3'd4,
		EV_SYNTAX    = 3'd5
	} ev_kind_t;

	typedef enum logic [2:0] {
		RK_IN         = 3'd0,
		RK_OUT        = 3'd1,
		RK_APPEND     = 3'd2,
		RK_ERR        = 3'd3,
		RK_ERR_APPEND = 3'd4
	} redir_t;

	typedef enum logic [1:0] {
		HOLD_NONE   = 2'd0,
		HOLD_TWO    = 2'd1,
		HOLD_GT     = 2'd2,
		HOLD_TWO_GT = 2'd3
	} hold_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] value;
		redir_t     rk;
	} event_t;

	// all events of one item, oldest in slot zero
	typedef struct packed {
		logic [2:0]                  cnt;
		event_t [MAX_EVENTS-1:0]     ev;
	} cmd_t;

	// length of an operator's text
	function automatic logic [1:0] op_len(redir_t k);
		case (k)
			RK_IN:         op_len = 2'd1;
			RK_OUT:        op_len = 2'd1;
			RK_APPEND:     op_len = 2'd2;
			RK_ERR:        op_len = 2'd2;
			RK_ERR_APPEND: op_len = 2'd3;
			default:       op_len = 2'd1;
		endcase
	endfunction

	// one byte of an operator's text
	function automatic logic [7:0] op_char(redir_t k, logic [1:0] i);
		case (k)
			RK_IN:         op_char = CH_LT;
			RK_OUT:        op_char = CH_GT;
			RK_APPEND:     op_char = CH_GT;
			RK_ERR:        op_char = (i == 2'd0) ? CH_TWO : CH_GT;
			RK_ERR_APPEND: op_char = (i == 2'd0) ? CH_TWO : CH_GT;
			default:       op_char = CH_GT;
		endcase
	endfunction

endpackage

/* rtl/core/srt_front.sv */
module srt_front import srt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] char_code,
	input  logic       line_end,
	input  logic       q_full,
	output logic       full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic   inside_q, target_q, await_q, comment_q;
	hold_t  hold_q;
	redir_t pend_q;

	logic   nx_inside, nx_target, nx_await, nx_comment, consumed, gt, acc;
	hold_t  nx_hold, held;
	redir_t nx_pend, rk_res;
	logic   op_res;
	cmd_t   cmd_d;

	// append one event to a command
	function automatic cmd_t add_ev(cmd_t c, ev_kind_t k, logic [7:0] v, redir_t r);
		cmd_t o;
		o = c;
		if (c.cnt < 3'(MAX_EVENTS)) begin
			o.ev[c.cnt[1:0]] = '{kind: k, value: v, rk: r};
			o.cnt = c.cnt + 3'd1;
		end
		return o;
	endfunction

	assign full   = q_full;
	assign acc    = push && !q_full;
	assign q_push = acc && (cmd_d.cnt != 3'd0);
	assign q_cmd  = cmd_d;

	// classify one item: events and next lexer state
	always_comb begin
		nx_inside  = inside_q;
		nx_target  = target_q;
		nx_hold    = hold_q;
		nx_await   = await_q;
		nx_pend    = pend_q;
		nx_comment = comment_q;
		cmd_d      = '0;
		consumed   = 1'b0;
		op_res     = 1'b0;
		rk_res     = RK_OUT;
		gt         = !line_end && (char_code == CH_GT);

		// resolve held lookahead
		held    = hold_q;
		nx_hold = HOLD_NONE;
		case (held)
			HOLD_TWO: begin
				if (gt) begin
					if (nx_inside) begin
						cmd_d = add_ev(cmd_d, nx_target ? EV_TGT_END : EV_ARG_END, 8'd0,
							nx_target ? nx_pend : RK_IN);
						nx_inside = 1'b0;
						nx_target = 1'b0;
					end
					nx_hold  = HOLD_TWO_GT;
					consumed = 1'b1;
				end else begin
					if (!nx_inside) begin
						nx_inside = 1'b1;
						if (nx_await) begin
							nx_target = 1'b1;
							nx_await  = 1'b0;
						end
					end
					cmd_d = add_ev(cmd_d, nx_target ? EV_TGT_BYTE : EV_ARG_BYTE, CH_TWO,
						nx_target ? nx_pend : RK_IN);
				end
			end
			HOLD_GT: begin
				op_res   = 1'b1;
				rk_res   = gt ? RK_APPEND : RK_OUT;
				consumed = gt;
			end
			HOLD_TWO_GT: begin
				op_res   = 1'b1;
				rk_res   = gt ? RK_ERR_APPEND : RK_ERR;
				consumed = gt;
			end
			default: ;
		endcase

		// operator completed by the lookahead
		if (op_res) begin
			if (nx_await) begin
				for (int i = 0; i < 3; i++) begin
					if (i < int'(op_len(rk_res)))
						cmd_d = add_ev(cmd_d, EV_TGT_BYTE, op_char(rk_res, 2'(i)), nx_pend);
				end
				cmd_d    = add_ev(cmd_d, EV_TGT_END, 8'd0, nx_pend);
				nx_await = 1'b0;
			end else begin
				nx_await = 1'b1;
				nx_pend  = rk_res;
			end
		end

		if (line_end) begin
			// close the line, then back to the reset state
			if (nx_inside)
				cmd_d = add_ev(cmd_d, nx_target ? EV_TGT_END : EV_ARG_END, 8'd0,
					nx_target ? nx_pend : RK_IN);
			if (nx_await)
				cmd_d = add_ev(cmd_d, EV_SYNTAX, 8'd0, nx_pend);
			cmd_d      = add_ev(cmd_d, EV_LINE_DONE, 8'd0, RK_IN);
			nx_inside  = 1'b0;
			nx_target  = 1'b0;
			nx_hold    = HOLD_NONE;
			nx_await   = 1'b0;
			nx_pend    = RK_IN;
			nx_comment = 1'b0;
		end else if (!consumed && !nx_comment) begin
			// ordinary byte
			if (char_code == CH_HASH && !nx_inside) begin
				nx_comment = 1'b1;
			end else if (char_code == CH_TWO) begin
				nx_hold = HOLD_TWO;
			end else if (char_code == CH_GT || char_code == CH_LT
					|| char_code inside {[8'd9:8'd13], 8'd32}) begin
				if (nx_inside) begin
					cmd_d = add_ev(cmd_d, nx_target ? EV_TGT_END : EV_ARG_END, 8'd0,
						nx_target ? nx_pend : RK_IN);
					nx_inside = 1'b0;
					nx_target = 1'b0;
				end
				if (char_code == CH_GT) begin
					nx_hold = HOLD_GT;
				end else if (char_code == CH_LT) begin
					if (nx_await) begin
						cmd_d    = add_ev(cmd_d, EV_TGT_BYTE, CH_LT, nx_pend);
						cmd_d    = add_ev(cmd_d, EV_TGT_END, 8'd0, nx_pend);
						nx_await = 1'b0;
					end else begin
						nx_await = 1'b1;
						nx_pend  = RK_IN;
					end
				end
			end else begin
				if (!nx_inside) begin
					nx_inside = 1'b1;
					if (nx_await) begin
						nx_target = 1'b1;
						nx_await  = 1'b0;
					end
				end
				cmd_d = add_ev(cmd_d, nx_target ? EV_TGT_BYTE : EV_ARG_BYTE, char_code,
					nx_target ? nx_pend : RK_IN);
			end
		end
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			target_q  <= 1'b0;
			hold_q    <= HOLD_NONE;
			await_q   <= 1'b0;
			pend_q    <= RK_IN;
			comment_q <= 1'b0;
		end else if (acc) begin
			inside_q  <= nx_inside;
			target_q  <= nx_target;
			hold_q    <= nx_hold;
			await_q   <= nx_await;
			pend_q    <= nx_pend;
			comment_q <= nx_comment;
		end
	end

endmodule

/* rtl/core/srt_cmd_queue.sv */
module srt_cmd_queue import srt_pkg::*; #(
	parameter int DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* rtl/core/srt_back.sv */
module srt_back import srt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] event_kind,
	output logic [7:0] byte_value,
	output logic [2:0] redirect_kind,
	output logic       last_of_run
);

	logic [1:0] idx_q;
	logic       out_valid_q, last_q;
	event_t     out_q;
	logic       load, is_last;

	assign is_last = ({1'b0, idx_q} == head_cmd.cnt - 3'd1);
	assign load    = head_valid && (!out_valid_q || pop);
	assign q_pop   = load && is_last;

	assign empty         = !out_valid_q;
	assign event_kind    = out_q.kind;
	assign byte_value    = out_q.value;
	assign redirect_kind = out_q.rk;
	assign last_of_run   = last_q;

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= head_cmd.ev[idx_q];
			last_q <= is_last;
		end
	end

	// slot walk and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	// a queued command always carries at least one event
	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> head_cmd.cnt != 3'd0)
		else $error("queued command without events");

	// the slot index never runs past the command's events
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, idx_q} < head_cmd.cnt)
		else $error("slot index beyond event count");

	// a command stays at the head until its last event has gone out
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !is_last) |=> head_valid)
		else $error("command left the queue before its last event");

	// a nonzero slot index only moves on a load
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0 && !load) |=> $stable(idx_q))
		else $error("slot index moved without a load");

endmodule

/* rtl/core/shell_redirect_tokenizer.sv */
// channel   dir  handshake             payload
// input     in   push / full           char_code[7:0], line_end
// result    out  pop / empty           event_kind[2:0], byte_value[7:0],
//                                      redirect_kind[2:0], last_of_run
//
// an item is taken each cycle while the command queue has room
// the expander sends one event per cycle while the result side pops, and a queued item
// yields one to four events; items without events are not queued
// the first event of an item passes through the command queue and then the result register
// arst_n clears the lexer state and empties the command queue and the result register
// a stalled result side fills the queue and then raises full
module shell_redirect_tokenizer import srt_pkg::*; #(
	parameter int CMD_DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       line_end,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] event_kind,
	output logic [7:0] byte_value,
	output logic [2:0] redirect_kind,
	output logic       last_of_run
);

	logic q_full, q_push, head_valid, q_pop;
	cmd_t q_cmd, head_cmd;

	// classifier
	srt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.line_end  (line_end),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	// command queue
	srt_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop)
	);

	// event expander
	srt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.event_kind    (event_kind),
		.byte_value    (byte_value),
		.redirect_kind (redirect_kind),
		.last_of_run   (last_of_run)
	);

endmodule
